// File: hdl/lps_pkg.sv
// Package for the LED pattern sequencer: item and result types, byte codes,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package lps_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] command;
        logic [7:0] data0;
        logic [7:0] data1;
        logic [7:0] data2;
        logic [7:0] data3;
    } item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } result_t;

    // Item opcodes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Item commands: CMD_END ends edit mode, the others act outside edit mode.
    localparam logic [7:0] CMD_END   = 8'h00;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_RUN   = 8'h02;
    localparam logic [7:0] CMD_PAUSE = 8'h03;
    localparam logic [7:0] CMD_EDIT  = 8'h04;

    // Program instruction codes.
    localparam logic [7:0] CODE_END   = 8'h00;
    localparam logic [7:0] CODE_CLEAR = 8'h01;
    localparam logic [7:0] CODE_PIXEL = 8'h02;
    localparam logic [7:0] CODE_DELAY = 8'h03;
    localparam logic [7:0] CODE_FILL  = 8'h04;

    // Result actions.
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;

    // Instruction length in bytes; zero for anything that ends the program.
    function automatic logic [2:0] instr_len(input logic [7:0] code);
        logic [2:0] len;
        case (code)
            CODE_CLEAR: len = 3'd1;
            CODE_PIXEL: len = 3'd5;
            CODE_DELAY: len = 3'd2;
            CODE_FILL:  len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    typedef struct packed {
        logic capture;
        logic cur_zero;
        logic cur_from_pos;
        logic cur_inc;
        logic cur_add_len;
        logic pos_clr;
        logic pos_load;
        logic delay_clr;
        logic delay_dec;
        logic delay_load;
        logic code_from_mem;
        logic code_from_item;
        logic cnt_init;
        logic cnt_init_one;
        logic cnt_inc;
        logic op_shift;
        logic mem_wr_zero;
        logic mem_wr_app;
        logic out_load;
        logic out_clear;
        logic out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic       item_opcode;
        logic [7:0] item_code;
        logic [7:0] rd_byte;
        logic       delay_zero;
        logic       delay_one;
        logic       pos_zero;
        logic       cnt_done;
        logic       app_fits;
        logic       out_free;
    } dp_status_t;

endpackage

// File: hdl/lps_datapath.sv
// Datapath of the LED pattern sequencer: program memory, position, delay,
// operand registers and the result register.
// Depends on lps_pkg; driven by lps_controller through dp_cmd_t.
module lps_datapath #(
    parameter int PROGRAM_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lps_pkg::item_t      item,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  lps_pkg::dp_cmd_t    cmd,
    output lps_pkg::dp_status_t status,
    output lps_pkg::result_t    result,
    output logic                result_valid,
    input  logic                result_stall
);

    localparam int AW = $clog2(PROGRAM_BYTES);
    localparam int PW = $clog2(PROGRAM_BYTES + 1);
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(PROGRAM_BYTES);
    localparam logic [CW-1:0] LAST_C  = CW'(PROGRAM_BYTES - 1);
    localparam logic [PW-1:0] POS_MAX = PW'(PROGRAM_BYTES);

    lps_pkg::item_t   item_reg;
    lps_pkg::result_t result_reg, result_next;
    logic             result_valid_reg;
    logic [7:0]       pixel_count_reg;
    logic [CW-1:0]    cur_reg, cur_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       delay_reg, delay_next;
    logic [7:0]       code_reg, code_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [7:0]       pix_reg, red_reg, green_reg, blue_reg;

    logic [7:0]               mem [PROGRAM_BYTES];
    logic [PROGRAM_BYTES-1:0] valid_reg;
    logic [7:0]               rd_data_reg;
    logic                     rd_ok_reg;
    logic [AW-1:0]            rd_idx, wr_idx;
    logic                     rd_in_range, wr_en;
    logic [7:0]               wr_data, rd_byte;

    assign rd_byte = rd_ok_reg ? rd_data_reg : 8'h00;

    // The read address follows the cursor's next value, so the registered
    // read data always shows the byte under the current cursor.
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.cur_zero)
            cur_next = '0;
        else if (cmd.cur_from_pos)
            cur_next = {1'b0, pos_reg};
        else if (cmd.cur_inc)
            cur_next = cur_reg + CW'(1);
        else if (cmd.cur_add_len)
            cur_next = cur_reg + CW'(lps_pkg::instr_len(rd_byte));
    end

    assign rd_idx      = cur_next[AW-1:0];
    assign rd_in_range = (cur_next < DEPTH_C);
    assign wr_idx      = cur_reg[AW-1:0];
    assign wr_en       = (cmd.mem_wr_zero || cmd.mem_wr_app) && (cur_reg < DEPTH_C);

    always_comb
    begin
        if (cmd.mem_wr_zero)
            wr_data = lps_pkg::CODE_END;
        else
        begin
            case (cnt_reg)
                3'd0:    wr_data = code_reg;
                3'd1:    wr_data = item_reg.data0;
                3'd2:    wr_data = item_reg.data1;
                3'd3:    wr_data = item_reg.data2;
                default: wr_data = item_reg.data3;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        rd_data_reg <= mem[rd_idx];
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.pos_clr)
            pos_next = '0;
        else if (cmd.pos_load)
            pos_next = (cur_next > DEPTH_C) ? POS_MAX : cur_next[PW-1:0];

        delay_next = delay_reg;
        if (cmd.delay_clr)
            delay_next = 8'h00;
        else if (cmd.delay_dec)
            delay_next = delay_reg - 8'd1;
        else if (cmd.delay_load)
            delay_next = rd_byte;

        code_next = code_reg;
        if (cmd.code_from_mem)
            code_next = rd_byte;
        else if (cmd.code_from_item)
            code_next = item_reg.command;

        cnt_next = cnt_reg;
        if (cmd.cnt_init)
            cnt_next = {2'b00, cmd.cnt_init_one};
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + 3'd1;
    end

    always_comb
    begin
        result_next = '0;
        result_next.last = cmd.out_last;
        if (!cmd.out_clear)
        begin
            case (code_reg)
                lps_pkg::CODE_PIXEL:
                begin
                    result_next.action = lps_pkg::ACT_PIXEL;
                    result_next.pixel  = pix_reg;
                    result_next.red    = red_reg;
                    result_next.green  = green_reg;
                    result_next.blue   = blue_reg;
                end
                lps_pkg::CODE_FILL:
                begin
                    result_next.action = lps_pkg::ACT_FILL;
                    result_next.pixel  = pixel_count_reg;
                    result_next.red    = red_reg;
                    result_next.green  = green_reg;
                    result_next.blue   = blue_reg;
                end
                default:
                    result_next.action = lps_pkg::ACT_CLEAR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            rd_ok_reg        <= 1'b0;
            cur_reg          <= '0;
            pos_reg          <= '0;
            delay_reg        <= 8'h00;
            code_reg         <= 8'h00;
            cnt_reg          <= 3'd0;
            pixel_count_reg  <= 8'h00;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_idx] <= 1'b1;
            rd_ok_reg <= rd_in_range && valid_reg[rd_idx];
            cur_reg   <= cur_next;
            pos_reg   <= pos_next;
            delay_reg <= delay_next;
            code_reg  <= code_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en)
                pixel_count_reg <= cfg_wr_data;
            if (cmd.out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
        if (cmd.op_shift)
        begin
            pix_reg   <= red_reg;
            red_reg   <= green_reg;
            green_reg <= blue_reg;
            blue_reg  <= rd_byte;
        end
        if (cmd.out_load)
            result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        status.item_opcode = item_reg.opcode;
        status.item_code   = item_reg.command;
        status.rd_byte     = rd_byte;
        status.delay_zero  = (delay_reg == 8'd0);
        status.delay_one   = (delay_reg == 8'd1);
        status.pos_zero    = (pos_reg == '0);
        status.cnt_done    = (cnt_reg == (lps_pkg::instr_len(code_reg) - 3'd1));
        // One byte always stays free for the terminator.
        status.app_fits    = (({1'b0, pos_reg} + CW'(lps_pkg::instr_len(item_reg.command)))
                              <= LAST_C);
        status.out_free    = !result_valid_reg || !result_stall;
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("program position beyond the store");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("byte counter beyond the longest instruction");

    a_clear_blank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.action == lps_pkg::ACT_CLEAR |->
            result_reg.pixel == 8'd0 && result_reg.red == 8'd0 &&
            result_reg.green == 8'd0 && result_reg.blue == 8'd0)
        else $error("clear result carries pixel or color data");
`endif

endmodule

// File: hdl/lps_controller.sv
// Controller of the LED pattern sequencer: decodes items, walks the program
// and sequences memory reads, writes and result loads.
// Depends on lps_pkg; drives lps_datapath through dp_cmd_t.
module lps_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  lps_pkg::dp_status_t status,
    output lps_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        MODE_PAUSED,
        MODE_RUNNING,
        MODE_EDIT
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_T_CODE,
        S_T_OPND,
        S_T_EMIT,
        S_T_DELAY,
        S_T_WRAP,
        S_C_CLEAR,
        S_C_RUN,
        S_C_WALK,
        S_E_TERM,
        S_E_APP
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   accept;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_IDLE;
                if (status.item_opcode == lps_pkg::OP_TICK)
                begin
                    if (mode_reg == MODE_RUNNING)
                    begin
                        if (status.delay_zero)
                        begin
                            cmd.cur_from_pos = 1'b1;
                            state_next       = S_T_CODE;
                        end
                        else
                        begin
                            cmd.delay_dec = 1'b1;
                            if (status.delay_one)
                            begin
                                cmd.cur_from_pos = 1'b1;
                                state_next       = S_T_CODE;
                            end
                        end
                    end
                end
                else if (mode_reg == MODE_EDIT)
                begin
                    if (status.item_code == lps_pkg::CMD_END)
                    begin
                        cmd.cur_from_pos = 1'b1;
                        state_next       = S_E_TERM;
                    end
                    else if (lps_pkg::instr_len(status.item_code) != 3'd0 && status.app_fits)
                    begin
                        cmd.code_from_item = 1'b1;
                        cmd.cur_from_pos   = 1'b1;
                        cmd.cnt_init       = 1'b1;
                        state_next         = S_E_APP;
                    end
                end
                else
                begin
                    case (status.item_code)
                        lps_pkg::CMD_CLEAR:
                        begin
                            mode_next     = MODE_PAUSED;
                            cmd.pos_clr   = 1'b1;
                            cmd.delay_clr = 1'b1;
                            cmd.cur_zero  = 1'b1;
                            state_next    = S_C_CLEAR;
                        end
                        lps_pkg::CMD_RUN:
                        begin
                            if (mode_reg != MODE_RUNNING)
                            begin
                                cmd.cur_zero = 1'b1;
                                state_next   = S_C_RUN;
                            end
                        end
                        lps_pkg::CMD_PAUSE:
                        begin
                            mode_next     = MODE_PAUSED;
                            cmd.delay_clr = 1'b1;
                        end
                        lps_pkg::CMD_EDIT:
                        begin
                            mode_next     = MODE_EDIT;
                            cmd.delay_clr = 1'b1;
                            cmd.cur_zero  = 1'b1;
                            state_next    = S_C_WALK;
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end

            S_T_CODE:
            begin
                case (status.rd_byte)
                    lps_pkg::CODE_CLEAR:
                    begin
                        cmd.code_from_mem = 1'b1;
                        cmd.cur_inc       = 1'b1;
                        state_next        = S_T_EMIT;
                    end
                    lps_pkg::CODE_PIXEL, lps_pkg::CODE_FILL:
                    begin
                        cmd.code_from_mem = 1'b1;
                        cmd.cur_inc       = 1'b1;
                        cmd.cnt_init      = 1'b1;
                        cmd.cnt_init_one  = 1'b1;
                        state_next        = S_T_OPND;
                    end
                    lps_pkg::CODE_DELAY:
                    begin
                        cmd.cur_inc = 1'b1;
                        state_next  = S_T_DELAY;
                    end
                    default:
                    begin
                        cmd.pos_clr = 1'b1;
                        state_next  = S_IDLE;
                    end
                endcase
            end

            S_T_OPND:
            begin
                cmd.op_shift = 1'b1;
                cmd.cur_inc  = 1'b1;
                if (status.cnt_done)
                    state_next = S_T_EMIT;
                else
                    cmd.cnt_inc = 1'b1;
            end

            // The byte under the cursor is the next instruction; it tells
            // whether this result is the item's last one.
            S_T_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = !(status.rd_byte inside
                        {lps_pkg::CODE_CLEAR, lps_pkg::CODE_PIXEL, lps_pkg::CODE_FILL});
                    if (status.rd_byte inside {lps_pkg::CODE_CLEAR, lps_pkg::CODE_PIXEL,
                                               lps_pkg::CODE_DELAY, lps_pkg::CODE_FILL})
                        state_next = S_T_CODE;
                    else
                    begin
                        cmd.pos_clr = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_T_DELAY:
            begin
                cmd.delay_load = 1'b1;
                cmd.cur_inc    = 1'b1;
                state_next     = S_T_WRAP;
            end

            S_T_WRAP:
            begin
                if (status.rd_byte inside {lps_pkg::CODE_CLEAR, lps_pkg::CODE_PIXEL,
                                           lps_pkg::CODE_DELAY, lps_pkg::CODE_FILL})
                    cmd.pos_load = 1'b1;
                else
                    cmd.pos_clr = 1'b1;
                state_next = S_IDLE;
            end

            S_C_CLEAR:
            begin
                if (status.out_free)
                begin
                    cmd.mem_wr_zero = 1'b1;
                    cmd.out_load    = 1'b1;
                    cmd.out_clear   = 1'b1;
                    cmd.out_last    = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_C_RUN:
            begin
                if (!status.pos_zero || status.rd_byte != lps_pkg::CODE_END)
                    mode_next = MODE_RUNNING;
                state_next = S_IDLE;
            end

            S_C_WALK:
            begin
                if (lps_pkg::instr_len(status.rd_byte) != 3'd0)
                    cmd.cur_add_len = 1'b1;
                else if (status.out_free)
                begin
                    cmd.pos_load  = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_clear = 1'b1;
                    cmd.out_last  = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_E_TERM:
            begin
                cmd.mem_wr_zero = 1'b1;
                cmd.pos_clr     = 1'b1;
                mode_next       = MODE_PAUSED;
                state_next      = S_IDLE;
            end

            S_E_APP:
            begin
                cmd.mem_wr_app = 1'b1;
                cmd.cur_inc    = 1'b1;
                if (status.cnt_done)
                begin
                    cmd.pos_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                    cmd.cnt_inc = 1'b1;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_PAUSED;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_DECODE)
        else $error("accepted item not decoded in the next cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while still held");

    a_append_edit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr_app |-> mode_reg == MODE_EDIT)
        else $error("program append outside edit mode");
`endif

endmodule

// File: hdl/led_pattern_sequencer_top.sv
// Top level of the LED pattern sequencer: joins the controller and datapath.
// Depends on lps_pkg, lps_controller and lps_datapath.
//
//   channel   direction  handshake                      payload
//   item      in         item_valid / item_stall        lps_pkg::item_t
//   result    out        result_valid / result_stall    lps_pkg::result_t
//   config    in         cfg_wr_en (no wait)            cfg_wr_data = pixel_count
//
// An item is decoded in the cycle after it is taken. A tick that runs the program
// walks it byte by byte, and emits its results, through the single read port of
// the program memory. An edit walk steps over each stored instruction, and an
// append writes its bytes into the program memory one by one.
// Reset is asynchronous; the program reads as all zero after reset.
// A stalled result holds the block only when the next result is ready to load.
module led_pattern_sequencer_top #(
    parameter int PROGRAM_BYTES = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  lps_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output lps_pkg::result_t result,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data
);

    lps_pkg::dp_cmd_t    cmd;
    lps_pkg::dp_status_t status;

    lps_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    lps_datapath #(
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
